// ===== src/rmq_pkg.sv =====
// ---------------------------------------------------------------------------
// rmq_pkg: shared types for the rotation matrix to quaternion core
// Word formats of the matrix input and quaternion result channels, and the
// branch codes of Shepperd's method.
// ---------------------------------------------------------------------------
package rmq_pkg;

  // Width of every matrix element and quaternion component.
  localparam int DATA_W = 16;

  // Which form of the conversion produced a result.
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_ROW0  = 2'd1,
    BR_ROW1  = 2'd2,
    BR_ROW2  = 2'd3
  } rmq_branch_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] m_r0c0;
    logic signed [DATA_W-1:0] m_r0c1;
    logic signed [DATA_W-1:0] m_r0c2;
    logic signed [DATA_W-1:0] m_r1c0;
    logic signed [DATA_W-1:0] m_r1c1;
    logic signed [DATA_W-1:0] m_r1c2;
    logic signed [DATA_W-1:0] m_r2c0;
    logic signed [DATA_W-1:0] m_r2c1;
    logic signed [DATA_W-1:0] m_r2c2;
  } rmq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quat_w;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    rmq_branch_t              branch_taken;
    logic                     degenerate;
  } rmq_out_t;

endpackage

// ===== src/rmq_sqrt_pipe.sv =====
// ---------------------------------------------------------------------------
// rmq_sqrt_pipe: pipelined integer square root
// Digit-by-digit floor square root, one root bit per register stage. A side
// word travels alongside each operand.
// ---------------------------------------------------------------------------
module rmq_sqrt_pipe #(
  parameter int XW     = 32,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [XW-1:0]       in_x,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [XW/2-1:0]     out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RTW = XW / 2;

  logic [RTW:0]        vld_s;
  logic [XW-1:0]       x_s    [RTW+1];
  logic [RTW:0]        rem_s  [RTW+1];
  logic [RTW-1:0]      root_s [RTW+1];
  logic [SIDE_W-1:0]   side_s [RTW+1];

  assign vld_s[0]  = in_valid;
  assign x_s[0]    = in_x;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = in_side;

  // One stage per root bit: bring down two radicand bits, try 4*root+1.
  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [RTW+2:0] rem_sh;
    logic [RTW+2:0] trial;
    logic [RTW+2:0] diff;
    logic           ge;
    logic [RTW:0]   rem_nxt;
    logic           vld_r;
    logic [XW-1:0]  x_r;
    logic [RTW:0]   rem_r;
    logic [RTW-1:0] root_r;
    logic [SIDE_W-1:0] side_r;

    always_comb begin
      rem_sh  = {rem_s[k], x_s[k][XW-1:XW-2]};
      trial   = {1'b0, root_s[k], 2'b01};
      diff    = rem_sh - trial;
      ge      = (rem_sh >= trial);
      rem_nxt = ge ? diff[RTW:0] : rem_sh[RTW:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r    <= {x_s[k][XW-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= {root_s[k][RTW-2:0], ge};
        side_r <= side_s[k];
      end
    end

    assign vld_s[k+1]  = vld_r;
    assign x_s[k+1]    = x_r;
    assign rem_s[k+1]  = rem_r;
    assign root_s[k+1] = root_r;
    assign side_s[k+1] = side_r;
  end

  assign out_valid = vld_s[RTW];
  assign out_root  = root_s[RTW];
  assign out_side  = side_s[RTW];

  // The final remainder never exceeds twice the root.
  property p_rem_bound;
    @(posedge clk) disable iff (!rst_n)
      vld_s[RTW] |-> (rem_s[RTW] <= {root_s[RTW], 1'b0});
  endproperty
  a_rem_bound: assert property (p_rem_bound) else $error("sqrt remainder too large");

  // A zero radicand gives a zero first root bit.
  property p_zero_root;
    @(posedge clk) disable iff (!rst_n)
      (en && in_valid && (in_x == '0)) |=> (vld_s[1] && (root_s[1] == '0));
  endproperty
  a_zero_root: assert property (p_zero_root) else $error("sqrt first bit wrong");

  // The first stage starts from a cleared remainder, so its remainder is at most 3.
  property p_first_rem;
    @(posedge clk) disable iff (!rst_n)
      vld_s[1] |-> (rem_s[1] <= 3);
  endproperty
  a_first_rem: assert property (p_first_rem) else $error("sqrt first remainder");

endmodule

// ===== src/rmq_div_pipe.sv =====
// ---------------------------------------------------------------------------
// rmq_div_pipe: pipelined restoring divider, several lanes
// All lanes share one divisor; one quotient bit per register stage. The
// numerator register shifts out dividend bits and takes in quotient bits.
// ---------------------------------------------------------------------------
module rmq_div_pipe #(
  parameter int NW     = 32,
  parameter int DW_D   = 17,
  parameter int LANES  = 3,
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_num,
  input  logic [DW_D-1:0]            in_den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   out_quot,
  output logic [SIDE_W-1:0]          out_side
);

  logic [NW:0]                vld_s;
  logic [LANES-1:0][NW-1:0]   num_s  [NW+1];
  logic [LANES-1:0][DW_D-1:0] rem_s  [NW+1];
  logic [DW_D-1:0]            den_s  [NW+1];
  logic [SIDE_W-1:0]          side_s [NW+1];

  assign vld_s[0]  = in_valid;
  assign num_s[0]  = in_num;
  assign rem_s[0]  = '0;
  assign den_s[0]  = in_den;
  assign side_s[0] = in_side;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [LANES-1:0][NW-1:0]   num_nxt;
    logic [LANES-1:0][DW_D-1:0] rem_nxt;
    logic [DW_D:0]              rem_sh;
    logic [DW_D:0]              diff;
    logic                       ge;
    logic                       vld_r;
    logic [LANES-1:0][NW-1:0]   num_r;
    logic [LANES-1:0][DW_D-1:0] rem_r;
    logic [DW_D-1:0]            den_r;
    logic [SIDE_W-1:0]          side_r;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
      rem_sh = '0;
      diff   = '0;
      ge     = 1'b0;
      for (int l = 0; l < LANES; l++) begin
        rem_sh     = {rem_s[k][l], num_s[k][l][NW-1]};
        diff       = rem_sh - {1'b0, den_s[k]};
        ge         = (rem_sh >= {1'b0, den_s[k]});
        rem_nxt[l] = ge ? diff[DW_D-1:0] : rem_sh[DW_D-1:0];
        num_nxt[l] = {num_s[k][l][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r  <= num_nxt;
        rem_r  <= rem_nxt;
        den_r  <= den_s[k];
        side_r <= side_s[k];
      end
    end

    assign vld_s[k+1]  = vld_r;
    assign num_s[k+1]  = num_r;
    assign rem_s[k+1]  = rem_r;
    assign den_s[k+1]  = den_r;
    assign side_s[k+1] = side_r;
  end

  assign out_valid = vld_s[NW];
  assign out_quot  = num_s[NW];
  assign out_side  = side_s[NW];

  // With a nonzero divisor the final remainder of lane 0 stays below it.
  property p_rem_lt_den;
    @(posedge clk) disable iff (!rst_n)
      (vld_s[NW] && (den_s[NW] != '0)) |-> (rem_s[NW][0] < den_s[NW]);
  endproperty
  a_rem_lt_den: assert property (p_rem_lt_den) else $error("divider remainder too large");

  // The divisor is carried unchanged from the input into the first stage.
  property p_den_carry;
    @(posedge clk) disable iff (!rst_n)
      (en && vld_s[0]) |=> (den_s[1] == $past(den_s[0]));
  endproperty
  a_den_carry: assert property (p_den_carry) else $error("divisor lost in pipe");

  // Stalled stages keep their valid bits.
  property p_hold;
    @(posedge clk) disable iff (!rst_n)
      !en |=> (vld_s[NW:1] == $past(vld_s[NW:1]));
  endproperty
  a_hold: assert property (p_hold) else $error("divider pipe moved while stalled");

endmodule

// ===== src/rotation_matrix_to_quaternion_core.sv =====
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core: 3x3 rotation matrix to unit quaternion
// Shepperd's method in fixed point: trace or largest-diagonal branch, a
// pipelined square root, then three pipelined divisions by twice the root.
//
//   Channel  Direction  Handshake            Word
//   in_      in         in_valid / in_stall  rmq_in_t: nine matrix elements
//   out_     out        out_valid / out_stall rmq_out_t: w x y z, branch, flag
//
// One word per cycle is accepted while in_stall is low. The pipe has one
// setup stage, RTW square root stages, one stage that forms the numerators,
// NW divider stages, one rounding stage and the output register. Reset
// clears all valid bits. The output register has a skid entry behind it;
// the whole pipe holds only while that entry is full.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rmq_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output rmq_out_t out_word
);

  localparam int DW   = DATA_W;
  localparam int RW   = ((FRAC_BITS > DW) ? FRAC_BITS : DW) + 3;
  localparam int XW0  = RW - 1 + FRAC_BITS;
  localparam int XW   = XW0 + (XW0 % 2);
  localparam int RTW  = XW / 2;
  localparam int UW   = DW + 1;
  localparam int NW   = ((UW + FRAC_BITS > RTW) ? UW + FRAC_BITS : RTW) + 1;
  localparam int SQ_SIDE  = 3 + 3 * UW;
  localparam int DV_SIDE  = 6 + RTW;
  localparam logic signed [RW-1:0] ONE = RW'(1) <<< FRAC_BITS;
  localparam logic signed [NW:0] Q_HI = (NW+1)'((1 << (DW - 1)) - 1);
  localparam logic signed [NW:0] Q_LO = -((NW+1)'(1) <<< (DW - 1));

  logic en;

  // ---- Setup stage: trace, branch choice, radicand and numerator terms ----
  logic signed [RW-1:0] e00, e11, e22, trace, rad_nxt;
  logic signed [UW-1:0] n0_nxt, n1_nxt, n2_nxt;
  rmq_branch_t          br_nxt;

  logic                 s1_vld_r;
  logic signed [RW-1:0] s1_rad_r;
  logic signed [UW-1:0] s1_n0_r, s1_n1_r, s1_n2_r;
  rmq_branch_t          s1_br_r;

  always_comb begin
    e00   = RW'(in_word.m_r0c0);
    e11   = RW'(in_word.m_r1c1);
    e22   = RW'(in_word.m_r2c2);
    trace = e00 + e11 + e22;
    if (trace > 0) begin
      br_nxt  = BR_TRACE;
      rad_nxt = trace + ONE;
      n0_nxt  = UW'(in_word.m_r2c1) - UW'(in_word.m_r1c2);
      n1_nxt  = UW'(in_word.m_r0c2) - UW'(in_word.m_r2c0);
      n2_nxt  = UW'(in_word.m_r1c0) - UW'(in_word.m_r0c1);
    end else if ((e00 > e11) && (e00 > e22)) begin
      br_nxt  = BR_ROW0;
      rad_nxt = ONE + e00 - e11 - e22;
      n0_nxt  = UW'(in_word.m_r2c1) - UW'(in_word.m_r1c2);
      n1_nxt  = UW'(in_word.m_r0c1) + UW'(in_word.m_r1c0);
      n2_nxt  = UW'(in_word.m_r0c2) + UW'(in_word.m_r2c0);
    end else if (e11 > e22) begin
      br_nxt  = BR_ROW1;
      rad_nxt = ONE + e11 - e00 - e22;
      n0_nxt  = UW'(in_word.m_r0c2) - UW'(in_word.m_r2c0);
      n1_nxt  = UW'(in_word.m_r0c1) + UW'(in_word.m_r1c0);
      n2_nxt  = UW'(in_word.m_r1c2) + UW'(in_word.m_r2c1);
    end else begin
      br_nxt  = BR_ROW2;
      rad_nxt = ONE + e22 - e00 - e11;
      n0_nxt  = UW'(in_word.m_r1c0) - UW'(in_word.m_r0c1);
      n1_nxt  = UW'(in_word.m_r0c2) + UW'(in_word.m_r2c0);
      n2_nxt  = UW'(in_word.m_r1c2) + UW'(in_word.m_r2c1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rad_r <= rad_nxt;
      s1_n0_r  <= n0_nxt;
      s1_n1_r  <= n1_nxt;
      s1_n2_r  <= n2_nxt;
      s1_br_r  <= br_nxt;
    end
  end

  assign in_stall = !en;

  // ---- Square root of the radicand, scaled up by the fraction bits ----
  logic               s1_degen;
  logic [XW-1:0]      sq_x;
  logic               sq_vld;
  logic [RTW-1:0]     sq_root;
  logic [SQ_SIDE-1:0] sq_side;

  assign s1_degen = (s1_rad_r <= 0);
  assign sq_x     = s1_degen ? '0 : (XW'(s1_rad_r[RW-2:0]) << FRAC_BITS);

  rmq_sqrt_pipe #(
    .XW     (XW),
    .SIDE_W (SQ_SIDE)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_vld_r),
    .in_x      (sq_x),
    .in_side   ({s1_br_r, s1_degen, s1_n0_r, s1_n1_r, s1_n2_r}),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---- Numerator stage: magnitudes with half-divisor rounding term ----
  rmq_branch_t          sq_br;
  logic                 sq_degen;
  logic signed [UW-1:0] sq_n [3];
  logic [2:0]           neg_nxt;
  logic [2:0][NW-1:0]   num_nxt;
  logic [UW-1:0]        mag;
  logic [RTW:0]         root_inc;

  always_comb begin
    sq_br    = rmq_branch_t'(sq_side[SQ_SIDE-1 -: 2]);
    sq_degen = sq_side[3*UW] || (sq_root == '0);
    sq_n[0]  = sq_side[3*UW-1 -: UW];
    sq_n[1]  = sq_side[2*UW-1 -: UW];
    sq_n[2]  = sq_side[UW-1 -: UW];
    mag      = '0;
    for (int l = 0; l < 3; l++) begin
      neg_nxt[l] = sq_n[l][UW-1];
      mag        = neg_nxt[l] ? UW'(-sq_n[l]) : UW'(sq_n[l]);
      num_nxt[l] = (NW'(mag) << FRAC_BITS) + NW'(sq_root);
    end
    root_inc = {1'b0, sq_root} + 1'b1;
  end

  logic               s2_vld_r;
  logic [2:0][NW-1:0] s2_num_r;
  logic [RTW:0]       s2_den_r;
  logic [2:0]         s2_neg_r;
  logic [RTW-1:0]     s2_big_r;
  rmq_branch_t        s2_br_r;
  logic               s2_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_num_r   <= num_nxt;
      s2_den_r   <= {sq_root, 1'b0};
      s2_neg_r   <= neg_nxt;
      s2_big_r   <= root_inc[RTW:1];
      s2_br_r    <= sq_br;
      s2_degen_r <= sq_degen;
    end
  end

  // ---- Three divisions by twice the root ----
  logic               dv_vld;
  logic [2:0][NW-1:0] dv_quot;
  logic [DV_SIDE-1:0] dv_side;

  rmq_div_pipe #(
    .NW     (NW),
    .DW_D   (RTW + 1),
    .LANES  (3),
    .SIDE_W (DV_SIDE)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_vld_r),
    .in_num    (s2_num_r),
    .in_den    (s2_den_r),
    .in_side   ({s2_br_r, s2_degen_r, s2_neg_r, s2_big_r}),
    .out_valid (dv_vld),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // ---- Rounding stage: sign, saturation and placement by branch ----
  function automatic logic signed [DW-1:0] sat_q(input logic signed [NW:0] v);
    if (v > Q_HI) begin
      sat_q = Q_HI[DW-1:0];
    end else if (v < Q_LO) begin
      sat_q = Q_LO[DW-1:0];
    end else begin
      sat_q = v[DW-1:0];
    end
  endfunction

  rmq_branch_t           dv_br;
  logic                  dv_degen;
  logic [2:0]            dv_neg;
  logic [RTW-1:0]        dv_big;
  logic signed [NW:0]    qs;
  logic signed [DW-1:0]  qv [3];
  logic signed [DW-1:0]  big_sat;
  rmq_out_t              res_nxt;

  always_comb begin
    dv_br    = rmq_branch_t'(dv_side[DV_SIDE-1 -: 2]);
    dv_degen = dv_side[RTW+3];
    dv_neg   = dv_side[RTW+2 -: 3];
    dv_big   = dv_side[RTW-1:0];
    qs       = '0;
    for (int l = 0; l < 3; l++) begin
      qs    = dv_neg[l] ? -$signed({1'b0, dv_quot[l]}) : $signed({1'b0, dv_quot[l]});
      qv[l] = sat_q(qs);
    end
    big_sat = sat_q($signed((NW+1)'(dv_big)));
    res_nxt.branch_taken = dv_br;
    res_nxt.degenerate   = dv_degen;
    case (dv_br)
      BR_TRACE: begin
        res_nxt.quat_w = big_sat; res_nxt.quat_x = qv[0];
        res_nxt.quat_y = qv[1];   res_nxt.quat_z = qv[2];
      end
      BR_ROW0: begin
        res_nxt.quat_w = qv[0];   res_nxt.quat_x = big_sat;
        res_nxt.quat_y = qv[1];   res_nxt.quat_z = qv[2];
      end
      BR_ROW1: begin
        res_nxt.quat_w = qv[0];   res_nxt.quat_x = qv[1];
        res_nxt.quat_y = big_sat; res_nxt.quat_z = qv[2];
      end
      default: begin
        res_nxt.quat_w = qv[0];   res_nxt.quat_x = qv[1];
        res_nxt.quat_y = qv[2];   res_nxt.quat_z = big_sat;
      end
    endcase
    if (dv_degen) begin
      res_nxt.quat_w = '0;
      res_nxt.quat_x = '0;
      res_nxt.quat_y = '0;
      res_nxt.quat_z = '0;
    end
  end

  logic     s3_vld_r;
  rmq_out_t s3_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_word_r <= res_nxt;
    end
  end

  // ---- Output register with one skid entry ----
  logic     out_vld_r, skid_vld_r;
  rmq_out_t out_word_r, skid_word_r;
  logic     taken, push;

  assign en    = !skid_vld_r;
  assign taken = out_vld_r && !out_stall;
  assign push  = en && s3_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (taken) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_r && !taken) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (taken) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (taken) begin
        out_word_r <= skid_word_r;
      end
    end else if (push) begin
      if (out_vld_r && !taken) begin
        skid_word_r <= s3_word_r;
      end else begin
        out_word_r <= s3_word_r;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  // The skid entry is only filled behind a waiting output word.
  property p_skid_behind_out;
    @(posedge clk) disable iff (!rst_n)
      skid_vld_r |-> out_vld_r;
  endproperty
  a_skid_behind_out: assert property (p_skid_behind_out) else $error("skid without output");

  // A degenerate result carries an all-zero quaternion.
  property p_degen_zero;
    @(posedge clk) disable iff (!rst_n)
      (out_vld_r && out_word_r.degenerate) |->
        ((out_word_r.quat_w == '0) && (out_word_r.quat_x == '0) &&
         (out_word_r.quat_y == '0) && (out_word_r.quat_z == '0));
  endproperty
  a_degen_zero: assert property (p_degen_zero) else $error("degenerate word not zero");

  // A word arriving at a held output goes to the skid entry.
  property p_skid_fill;
    @(posedge clk) disable iff (!rst_n)
      (push && out_vld_r && out_stall) |=> skid_vld_r;
  endproperty
  a_skid_fill: assert property (p_skid_fill) else $error("word dropped at output");

endmodule
